// ----- hw/rtl/hwf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwf_pkg
// Shared types, wave constants and sine table generator for the wave height
// field block.
// ----------------------------------------------------------------------------
package hwf_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_SQ_START,
        S_SQRT,
        S_DIV,
        S_OUT
    } state_t;

    localparam int MUL_A_W   = 33;
    localparam int MUL_B_W   = 31;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int ACC_W     = 48;
    localparam int SUMSQ_W   = 40;
    localparam int SQ_N_W    = 60;
    localparam int SQ_R_W    = 30;
    localparam int DIV_MAG_W = 18;
    localparam int DIV_Q_W   = 17;

    localparam logic signed [MUL_B_W-1:0] KX1  = 31'sd536232718;
    localparam logic signed [MUL_B_W-1:0] KZ1  = 31'sd107246544;
    localparam logic signed [MUL_B_W-1:0] KT1  = 31'sd193043779;
    localparam logic signed [MUL_B_W-1:0] KX2  = 31'sd80434908;
    localparam logic signed [MUL_B_W-1:0] KZ2  = 31'sd402174539;
    localparam logic signed [MUL_B_W-1:0] KT2  = 31'sd96521889;
    localparam logic signed [MUL_B_W-1:0] AMP1 = 31'sd39322;
    localparam logic signed [MUL_B_W-1:0] AMP2 = 31'sd19661;

    localparam logic [SUMSQ_W-1:0] B_SQUARED = 40'h04_0000_0000;
    localparam logic [DIV_MAG_W-1:0] B_MAG   = 18'h2_0000;
    localparam logic [DIV_Q_W-1:0]   Q_MAX   = 17'd32767;
    localparam logic signed [15:0]   N_ONE   = 16'sd32767;

    localparam logic [1:0] REG_TIME  = 2'd0;
    localparam logic [1:0] REG_THICK = 2'd1;
    localparam logic [1:0] REG_WIDTH = 2'd2;

    // sequencer steps
    localparam logic [3:0] ST_X1   = 4'd0;
    localparam logic [3:0] ST_Z1   = 4'd1;
    localparam logic [3:0] ST_T1   = 4'd2;
    localparam logic [3:0] ST_X2   = 4'd3;
    localparam logic [3:0] ST_Z2   = 4'd4;
    localparam logic [3:0] ST_T2   = 4'd5;
    localparam logic [3:0] ST_ACC  = 4'd6;
    localparam logic [3:0] ST_ROM1 = 4'd7;
    localparam logic [3:0] ST_AMP1 = 4'd8;
    localparam logic [3:0] ST_AMP2 = 4'd9;
    localparam logic [3:0] ST_SUMW = 4'd10;
    localparam logic [3:0] ST_WB   = 4'd11;
    localparam logic [3:0] ST_SQC  = 4'd12;
    localparam logic [3:0] ST_LAST = 4'd13;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] ONE_Q30     = 64'd1073741824;
    localparam logic [63:0] SINE_DIV [5] = '{64'd110, 64'd72, 64'd42, 64'd20, 64'd6};

    // quarter-wave series, evaluated at elaboration only
    function automatic logic signed [31:0] sine_entry(input int unsigned idx,
                                                      input int unsigned lg);
        logic [63:0] j;
        logic [63:0] quad;
        logic [63:0] rem;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        j    = 64'(idx) << 2;
        quad = j >> lg;
        rem  = j & ((64'd1 << lg) - 64'd1);
        if (quad[0])
        begin
            rem = (64'd1 << lg) - rem;
        end
        x  = (rem * HALF_PI_Q30) >> lg;
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        for (int k = 0; k < 5; k++)
        begin
            t = ONE_Q30 - (((x2 * t) >> 30) / SINE_DIV[k]);
        end
        s = (((x * t) >> 30) + 64'd8192) >> 14;
        return (quad >= 64'd2) ? -(32'(s)) : 32'(s);
    endfunction

endpackage

// ----- hw/rtl/hwf_isqrt.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwf_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module hwf_isqrt
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [hwf_pkg::SQ_N_W-1:0]    n_in,
    output logic                          done,
    output logic [hwf_pkg::SQ_R_W-1:0]    root
);

    localparam int NW = hwf_pkg::SQ_N_W;

    logic [NW-1:0] n_reg;
    logic [NW-1:0] res_reg;
    logic [NW-1:0] bit_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [NW-1:0] trial;

    assign trial = res_reg + bit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && bit_reg[0];
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= n_in;
            res_reg <= '0;
            bit_reg <= NW'(1) << (NW - 2);
        end
        else if (busy_reg)
        begin
            if (n_reg >= trial)
            begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[hwf_pkg::SQ_R_W-1:0];

endmodule

// ----- hw/rtl/hwf_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hwf_div
// Restoring divider for one normal component: round(mag * 2^25 / len).
// ----------------------------------------------------------------------------
module hwf_div
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [hwf_pkg::DIV_MAG_W-1:0]  mag,
    input  logic [hwf_pkg::SQ_R_W-1:0]     len,
    output logic                           done,
    output logic [hwf_pkg::DIV_Q_W-1:0]    quot
);

    localparam int QW = hwf_pkg::DIV_Q_W;
    localparam int RW = hwf_pkg::DIV_MAG_W + 26;
    localparam int DW = hwf_pkg::SQ_R_W + QW - 1;
    localparam int CW = $clog2(QW + 1);

    logic [RW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] q_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW-1:0] rem_ext;
    logic          last;

    assign rem_ext = DW'(rem_reg);
    assign last    = (cnt_reg == CW'(QW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= {mag, 25'b0} + RW'(len >> 1);
            den_reg <= DW'(len) << (QW - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_ext >= den_reg)
            begin
                rem_reg <= RW'(rem_ext - den_reg);
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                q_reg <= {q_reg[QW-2:0], 1'b0};
            end
            den_reg <= den_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

// ----- hw/rtl/wave_height_field_normals_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wave_height_field_normals_top
// Two-wave sine height field over a raster-ordered grid with central
// difference normals taken from a two-row height store.
// ----------------------------------------------------------------------------
// Vertices enter on the s_ stream, one beat per vertex; s_tuser marks the first
// vertex of a frame. Each vertex gives one m_ beat: its top and bottom heights
// and the normal of the vertex one row and one column back (m_tuser high when
// that vertex is interior). Registers are written over the cfg_ channel, which
// is always ready; write them only between frames or while the block is idle.
// One vertex is in work at a time. A vertex is worked through a 14-step
// sequence around one shared 33x31 multiplier and the row store. An interior
// vertex then adds a square root and a divide (three lanes in parallel).
// The result sits in an output register; the next vertex is taken while it
// waits, and a stalled m_ side holds the block only once that vertex is done.
// Reset clears the counters, recent heights and registers to their defaults;
// the row store needs no clearing, every entry is written before its value is used.
// ----------------------------------------------------------------------------
module wave_height_field_normals_top
#(
    parameter int MAX_GRID_WIDTH   = 256,
    parameter int SINE_TABLE_DEPTH = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,   // pos_x, pos_z
    input  logic         s_tuser,   // frame_start
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // top_height, bottom_height, normal_x, normal_y,
                                    // normal_z, normal_column, normal_row
    output logic         m_tuser,   // normal_valid
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int CW   = $clog2(MAX_GRID_WIDTH);
    localparam int CXW  = (CW > 8) ? CW : 8;
    localparam int GW_W = ($clog2(MAX_GRID_WIDTH + 1) > 9) ? $clog2(MAX_GRID_WIDTH + 1) : 9;
    localparam int AW   = $clog2(2 * MAX_GRID_WIDTH);
    localparam int LG   = $clog2(SINE_TABLE_DEPTH);
    localparam int MAW  = hwf_pkg::MUL_A_W;
    localparam int MBW  = hwf_pkg::MUL_B_W;

    hwf_pkg::state_t state_reg;
    hwf_pkg::state_t state_next;

    logic [31:0]        time_reg;
    logic [31:0]        thick_reg;
    logic [8:0]         width_reg;
    logic [CW-1:0]      col_cnt_reg;
    logic [7:0]         row_cnt_reg;
    logic [3:0]         step_reg;

    logic signed [31:0] px_reg;
    logic signed [31:0] pz_reg;
    logic [CW-1:0]      c_reg;
    logic [7:0]         r_reg;
    logic               valid_reg;

    logic [hwf_pkg::ACC_W-1:0]   acc1_reg;
    logic [hwf_pkg::ACC_W-1:0]   acc2_reg;
    logic signed [hwf_pkg::PROD_W-1:0] prod_reg;
    logic signed [31:0] top_reg;
    logic signed [31:0] bottom_reg;
    logic signed [31:0] old_reg;
    logic signed [31:0] yl_reg;
    logic signed [31:0] yr_reg;
    logic signed [31:0] rh0_reg;
    logic signed [31:0] rh1_reg;
    logic signed [32:0] a_reg;
    logic signed [32:0] cc_reg;
    logic [hwf_pkg::SUMSQ_W-1:0] sumsq_reg;

    logic [31:0]        mem_q_reg;
    logic [31:0]        row_mem [2*MAX_GRID_WIDTH];
    logic [AW-1:0]      mem_addr;
    logic               mem_we;

    logic signed [31:0] sine_rom [SINE_TABLE_DEPTH];
    logic signed [31:0] rom_q_reg;
    logic [LG-1:0]      rom_addr;

    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [hwf_pkg::PROD_W-1:0] wave_rnd;

    logic               m_tvalid_reg;
    logic [127:0]       m_tdata_reg;
    logic               m_tuser_reg;
    logic               out_free;

    logic [GW_W-1:0]    gw_eff;
    logic [CW-1:0]      c_new;
    logic [7:0]         r_new;
    logic               accept;

    logic               sqrt_start;
    logic               sqrt_done;
    logic [hwf_pkg::SQ_R_W-1:0] sqrt_root;
    logic               div_start;
    logic [2:0]         div_done;
    logic [hwf_pkg::DIV_Q_W-1:0]   div_q [3];
    logic [hwf_pkg::DIV_MAG_W-1:0] div_mag [3];

    logic signed [33:0] bottom_full;
    logic [CXW-1:0]     c_ext;

    // ---- sine table
    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++)
    begin : g_sine
        assign sine_rom[gi] = hwf_pkg::sine_entry(gi, LG);
    end

    function automatic logic signed [15:0] comp(input logic neg,
                                                input logic [hwf_pkg::DIV_Q_W-1:0] q);
        logic [15:0] m;
        m = (q > hwf_pkg::Q_MAX) ? 16'(hwf_pkg::Q_MAX) : 16'(q);
        return neg ? -m : m;
    endfunction

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == hwf_pkg::S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // ---- grid position of the incoming vertex
    always_comb
    begin
        gw_eff = GW_W'(width_reg);
        if (gw_eff < GW_W'(3))
        begin
            gw_eff = GW_W'(3);
        end
        else if (gw_eff > GW_W'(MAX_GRID_WIDTH))
        begin
            gw_eff = GW_W'(MAX_GRID_WIDTH);
        end
        c_new = s_tuser ? '0 : col_cnt_reg;
        r_new = s_tuser ? '0 : row_cnt_reg;
        if (GW_W'(c_new) >= gw_eff)
        begin
            c_new = '0;
            r_new = r_new + 8'd1;
        end
    end

    // ---- sequencer
    always_comb
    begin
        state_next = state_reg;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            hwf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    state_next = hwf_pkg::S_RUN;
                end
            end
            hwf_pkg::S_RUN:
            begin
                if (step_reg == hwf_pkg::ST_LAST)
                begin
                    state_next = valid_reg ? hwf_pkg::S_SQ_START : hwf_pkg::S_OUT;
                end
            end
            hwf_pkg::S_SQ_START:
            begin
                sqrt_start = 1'b1;
                state_next = hwf_pkg::S_SQRT;
            end
            hwf_pkg::S_SQRT:
            begin
                if (sqrt_done)
                begin
                    div_start  = 1'b1;
                    state_next = hwf_pkg::S_DIV;
                end
            end
            hwf_pkg::S_DIV:
            begin
                if (div_done[0])
                begin
                    state_next = hwf_pkg::S_OUT;
                end
            end
            hwf_pkg::S_OUT:
            begin
                if (out_free)
                begin
                    state_next = hwf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = hwf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hwf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---- control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            thick_reg    <= 32'd131072;
            width_reg    <= 9'd200;
            col_cnt_reg  <= '0;
            row_cnt_reg  <= '0;
            step_reg     <= '0;
            valid_reg    <= 1'b0;
            rh0_reg      <= '0;
            rh1_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    hwf_pkg::REG_TIME:  time_reg  <= cfg_data;
                    hwf_pkg::REG_THICK: thick_reg <= cfg_data;
                    hwf_pkg::REG_WIDTH: width_reg <= cfg_data[8:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                step_reg  <= '0;
                valid_reg <= (c_new >= CW'(2)) && (r_new >= 8'd2);
                if (GW_W'(c_new) + GW_W'(1) >= gw_eff)
                begin
                    col_cnt_reg <= '0;
                    row_cnt_reg <= r_new + 8'd1;
                end
                else
                begin
                    col_cnt_reg <= c_new + CW'(1);
                    row_cnt_reg <= r_new;
                end
            end
            else if (state_reg == hwf_pkg::S_RUN)
            begin
                step_reg <= step_reg + 4'd1;
            end
            if (state_reg == hwf_pkg::S_RUN && step_reg == hwf_pkg::ST_WB)
            begin
                rh0_reg <= top_reg;
                rh1_reg <= old_reg;
            end
            if (state_reg == hwf_pkg::S_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // ---- shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            hwf_pkg::ST_X1:   begin mul_a = MAW'(px_reg); mul_b = hwf_pkg::KX1; end
            hwf_pkg::ST_Z1:   begin mul_a = MAW'(pz_reg); mul_b = hwf_pkg::KZ1; end
            hwf_pkg::ST_T1:   begin mul_a = {1'b0, time_reg}; mul_b = hwf_pkg::KT1; end
            hwf_pkg::ST_X2:   begin mul_a = MAW'(px_reg); mul_b = hwf_pkg::KX2; end
            hwf_pkg::ST_Z2:   begin mul_a = MAW'(pz_reg); mul_b = hwf_pkg::KZ2; end
            hwf_pkg::ST_T2:   begin mul_a = {1'b0, time_reg}; mul_b = hwf_pkg::KT2; end
            hwf_pkg::ST_AMP1: begin mul_a = MAW'(rom_q_reg); mul_b = hwf_pkg::AMP1; end
            hwf_pkg::ST_AMP2: begin mul_a = MAW'(rom_q_reg); mul_b = hwf_pkg::AMP2; end
            hwf_pkg::ST_WB:   begin mul_a = a_reg; mul_b = a_reg[MBW-1:0]; end
            hwf_pkg::ST_SQC:  begin mul_a = cc_reg; mul_b = cc_reg[MBW-1:0]; end
            default: ;
        endcase
    end

    always_comb
    begin
        rom_addr = acc1_reg[hwf_pkg::ACC_W-1 -: LG];
        if (step_reg == hwf_pkg::ST_AMP1)
        begin
            rom_addr = acc2_reg[hwf_pkg::ACC_W-1 -: LG];
        end
    end

    always_comb
    begin
        mem_we   = (state_reg == hwf_pkg::S_RUN) && (step_reg == hwf_pkg::ST_WB);
        mem_addr = AW'(c_reg) + (r_reg[0] ? AW'(MAX_GRID_WIDTH) : AW'(0));
        if (step_reg == hwf_pkg::ST_Z1)
        begin
            mem_addr = AW'(c_reg - CW'(2)) + (r_reg[0] ? AW'(0) : AW'(MAX_GRID_WIDTH));
        end
        else if (step_reg == hwf_pkg::ST_T1)
        begin
            mem_addr = AW'(c_reg) + (r_reg[0] ? AW'(0) : AW'(MAX_GRID_WIDTH));
        end
    end

    assign wave_rnd    = prod_reg + 64'sd32768;
    assign bottom_full = 34'(top_reg) - 34'(thick_reg);

    // ---- row store and sine table
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[mem_addr] <= top_reg;
        end
        mem_q_reg <= row_mem[mem_addr];
        rom_q_reg <= sine_rom[rom_addr];
    end

    // ---- data path
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (accept)
        begin
            px_reg <= s_tdata[31:0];
            pz_reg <= s_tdata[63:32];
            c_reg  <= c_new;
            r_reg  <= r_new;
        end
        if (state_reg == hwf_pkg::S_RUN)
        begin
            case (step_reg)
                hwf_pkg::ST_Z1:
                begin
                    acc1_reg <= prod_reg[hwf_pkg::ACC_W-1:0];
                    old_reg  <= mem_q_reg;
                end
                hwf_pkg::ST_T1:
                begin
                    acc1_reg <= acc1_reg + prod_reg[hwf_pkg::ACC_W-1:0];
                    yl_reg   <= mem_q_reg;
                end
                hwf_pkg::ST_X2:
                begin
                    acc1_reg <= acc1_reg - prod_reg[hwf_pkg::ACC_W-1:0];
                    yr_reg   <= mem_q_reg;
                end
                hwf_pkg::ST_Z2:   acc2_reg <= prod_reg[hwf_pkg::ACC_W-1:0];
                hwf_pkg::ST_T2:   acc2_reg <= acc2_reg + prod_reg[hwf_pkg::ACC_W-1:0];
                hwf_pkg::ST_ACC:  acc2_reg <= acc2_reg - prod_reg[hwf_pkg::ACC_W-1:0];
                hwf_pkg::ST_ROM1:
                begin
                    a_reg  <= 33'(yl_reg) - 33'(yr_reg);
                    cc_reg <= 33'(rh1_reg) - 33'(rh0_reg);
                end
                hwf_pkg::ST_AMP2: top_reg <= wave_rnd[47:16];
                hwf_pkg::ST_SUMW: top_reg <= top_reg + wave_rnd[47:16];
                hwf_pkg::ST_WB:
                begin
                    bottom_reg <= (bottom_full < -34'sd2147483648) ? 32'sh8000_0000
                                                                   : bottom_full[31:0];
                end
                hwf_pkg::ST_SQC:  sumsq_reg <= prod_reg[hwf_pkg::SUMSQ_W-1:0];
                hwf_pkg::ST_LAST:
                begin
                    sumsq_reg <= sumsq_reg + prod_reg[hwf_pkg::SUMSQ_W-1:0]
                                 + hwf_pkg::B_SQUARED;
                end
                default: ;
            endcase
        end
    end

    // ---- square root and divider lanes
    hwf_isqrt u_isqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .n_in  ({sumsq_reg, 20'b0}),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    assign div_mag[0] = a_reg[32]  ? hwf_pkg::DIV_MAG_W'(-a_reg)  : hwf_pkg::DIV_MAG_W'(a_reg);
    assign div_mag[1] = hwf_pkg::B_MAG;
    assign div_mag[2] = cc_reg[32] ? hwf_pkg::DIV_MAG_W'(-cc_reg) : hwf_pkg::DIV_MAG_W'(cc_reg);

    for (genvar li = 0; li < 3; li++)
    begin : g_div
        hwf_div u_div
        (
            .clk   (clk),
            .rst_n (rst_n),
            .start (div_start),
            .mag   (div_mag[li]),
            .len   (sqrt_root),
            .done  (div_done[li]),
            .quot  (div_q[li])
        );
    end

    // ---- output register
    assign c_ext = CXW'(c_reg);

    always_ff @(posedge clk)
    begin
        if (state_reg == hwf_pkg::S_OUT && out_free)
        begin
            m_tdata_reg[31:0]    <= top_reg;
            m_tdata_reg[63:32]   <= bottom_reg;
            m_tdata_reg[79:64]   <= valid_reg ? comp(a_reg[32], div_q[0]) : 16'sd0;
            m_tdata_reg[95:80]   <= valid_reg ? comp(1'b0, div_q[1]) : hwf_pkg::N_ONE;
            m_tdata_reg[111:96]  <= valid_reg ? comp(cc_reg[32], div_q[2]) : 16'sd0;
            m_tdata_reg[119:112] <= 8'(c_ext - CXW'(1));
            m_tdata_reg[127:120] <= r_reg - 8'd1;
            m_tuser_reg          <= valid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ---- checks
    a_sqrt_interior: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> valid_reg)
        else $error("root started for a border vertex");

    a_sqrt_state: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == hwf_pkg::S_SQRT))
        else $error("root finished outside its wait state");

    a_div_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        div_done[0] |-> (div_done[1] && div_done[2]))
        else $error("divider lanes out of step");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hwf_pkg::S_OUT && out_free) |=>
            (m_tvalid && state_reg == hwf_pkg::S_IDLE))
        else $error("result beat not presented");

endmodule
